@@ rtl/core/pc_pkg.sv @@
// Shared types, widths and saturation helpers for the pose composition block.
// Used by every module under rtl/core; depends on nothing.
package pc_pkg;

  localparam int POS_W     = 24;
  localparam int QUAT_W    = 16;
  localparam int QUAT_FRAC = 14;
  localparam int STAGES    = 4;

  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = 136;

  // Rounded position sum before clamping, and rounded quaternion sum.
  localparam int POS_SUM_W  = 35;
  localparam int QUAT_RND_W = 20;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [QUAT_W-1:0] qcomp_t;

  // x sits in the lowest bits, as on the bus.
  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] x;
  } quat_t;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pos_vec_t;

  // One load enable per pipeline stage, shared by both datapaths.
  typedef struct packed {
    logic [STAGES-1:0] en;
  } pipe_ctrl_t;

  function automatic pos_t sat_pos(input logic signed [POS_SUM_W-1:0] val);
    if (val > 35'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (val < -35'sd8388608) begin
      return 24'sh800000;
    end
    return val[POS_W-1:0];
  endfunction

  function automatic qcomp_t sat_quat(input logic signed [QUAT_RND_W-1:0] val);
    if (val > 20'sd32767) begin
      return 16'sh7FFF;
    end else if (val < -20'sd32768) begin
      return 16'sh8000;
    end
    return val[QUAT_W-1:0];
  endfunction

endpackage

@@ rtl/core/pose_composition.sv @@
// Pose composition block: composes two rigid poses, applying first then second.
//
// Input words carry both poses; output words carry the composed position and
// orientation quaternion. Positions are signed Q12.12, quaternions Q2.14.
// Orientation is the Hamilton product second * first, not renormalised.
// Position is the first position rotated by the second quaternion, plus the
// second position. Products round to nearest; results saturate.
//
// From input handshake to output valid, each word passes through one stage of
// multipliers for u x v and the quaternion products, one for sums and rounding,
// one for the w*t and u x t multipliers, and the final sum with saturation in
// the output register. Throughput is one word per cycle with no stall.
// Each stage carries a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles are squeezed out. When the receiver stalls the
// output word holds and the pipeline keeps filling; in_tready falls only once
// all four stages are full. Synchronous reset clears the valid bits only.
// Depends on pc_pkg, pc_quat_mul and pc_rotate.
module pose_composition (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // first_pos_x, first_pos_y, first_pos_z, first_rotation,
  // second_pos_x, second_pos_y, second_pos_z, second_rotation
  input  logic [pc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_quat_x, out_quat_y, out_quat_z,
  // out_quat_w
  output logic [pc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic [pc_pkg::STAGES-1:0] valid_r;
  logic [pc_pkg::STAGES-1:0] valid_nxt;
  logic [pc_pkg::STAGES-1:0] stage_ready;
  pc_pkg::pipe_ctrl_t        ctrl;

  pc_pkg::pos_vec_t first_pos, second_pos, pos_res;
  pc_pkg::quat_t    first_rot, second_rot, quat_res;

  assign first_pos  = pc_pkg::pos_vec_t'(in_tdata[71:0]);
  assign first_rot  = pc_pkg::quat_t'(in_tdata[135:72]);
  assign second_pos = pc_pkg::pos_vec_t'(in_tdata[207:136]);
  assign second_rot = pc_pkg::quat_t'(in_tdata[271:208]);

  always_comb begin
    stage_ready[pc_pkg::STAGES-1] = !valid_r[pc_pkg::STAGES-1] || out_tready;
    for (int k = pc_pkg::STAGES - 2; k >= 0; k--) begin
      stage_ready[k] = !valid_r[k] || stage_ready[k+1];
    end
  end

  assign ctrl.en = stage_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (stage_ready[0]) begin
      valid_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < pc_pkg::STAGES; k++) begin
      if (stage_ready[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  pc_quat_mul u_quat_mul (
    .clk        (clk),
    .ctrl       (ctrl),
    .first_rot  (first_rot),
    .second_rot (second_rot),
    .quat_out   (quat_res)
  );

  pc_rotate u_rotate (
    .clk        (clk),
    .ctrl       (ctrl),
    .first_pos  (first_pos),
    .second_pos (second_pos),
    .second_rot (second_rot),
    .pos_out    (pos_res)
  );

  assign in_tready  = stage_ready[0];
  assign out_tvalid = valid_r[pc_pkg::STAGES-1];
  assign out_tdata  = {quat_res, pos_res};

endmodule

@@ rtl/core/pc_quat_mul.sv @@
// Hamilton product second * first over four stages: products, rounded sums,
// then two delay stages to line up with the rotation path. Uses pc_pkg.
module pc_quat_mul (
  input  logic               clk,
  input  pc_pkg::pipe_ctrl_t ctrl,
  input  pc_pkg::quat_t      first_rot,
  input  pc_pkg::quat_t      second_rot,
  output pc_pkg::quat_t      quat_out
);

  // Component index 0..3 = x, y, z, w.
  logic signed [15:0] a_c [4];
  logic signed [15:0] b_c [4];
  logic signed [31:0] prod_r [4][4];
  logic signed [31:0] prod_nxt [4][4];

  logic signed [33:0] sum_x, sum_y, sum_z, sum_w;
  pc_pkg::quat_t      q2_r, q2_nxt, q3_r, q4_r;

  assign a_c[0] = second_rot.x;
  assign a_c[1] = second_rot.y;
  assign a_c[2] = second_rot.z;
  assign a_c[3] = second_rot.w;
  assign b_c[0] = first_rot.x;
  assign b_c[1] = first_rot.y;
  assign b_c[2] = first_rot.z;
  assign b_c[3] = first_rot.w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = a_c[i] * b_c[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    sum_x = 34'(prod_r[3][0]) + 34'(prod_r[0][3]) + 34'(prod_r[1][2]) - 34'(prod_r[2][1]);
    sum_y = 34'(prod_r[3][1]) - 34'(prod_r[0][2]) + 34'(prod_r[1][3]) + 34'(prod_r[2][0]);
    sum_z = 34'(prod_r[3][2]) + 34'(prod_r[0][1]) - 34'(prod_r[1][0]) + 34'(prod_r[2][3]);
    sum_w = 34'(prod_r[3][3]) - 34'(prod_r[0][0]) - 34'(prod_r[1][1]) - 34'(prod_r[2][2]);
  end

  function automatic pc_pkg::qcomp_t round_sat(input logic signed [33:0] s);
    logic signed [33:0] rs;
    rs = (s + 34'sd8192) >>> pc_pkg::QUAT_FRAC;
    return pc_pkg::sat_quat(rs[pc_pkg::QUAT_RND_W-1:0]);
  endfunction

  always_comb begin
    q2_nxt.x = round_sat(sum_x);
    q2_nxt.y = round_sat(sum_y);
    q2_nxt.z = round_sat(sum_z);
    q2_nxt.w = round_sat(sum_w);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      q2_r <= q2_nxt;
    end
    if (ctrl.en[2]) begin
      q3_r <= q2_r;
    end
    if (ctrl.en[3]) begin
      q4_r <= q3_r;
    end
  end

  assign quat_out = q4_r;

endmodule

@@ rtl/core/pc_rotate.sv @@
// Rotates the first position by the second quaternion and adds the second
// position, over four stages with the last one as output register. Uses pc_pkg.
module pc_rotate (
  input  logic               clk,
  input  pc_pkg::pipe_ctrl_t ctrl,
  input  pc_pkg::pos_vec_t   first_pos,
  input  pc_pkg::pos_vec_t   second_pos,
  input  pc_pkg::quat_t      second_rot,
  output pc_pkg::pos_vec_t   pos_out
);

  // Axis index 0..2 = x, y, z.
  logic signed [23:0] v_in [3];
  logic signed [23:0] p2_in [3];
  logic signed [15:0] u_in [3];

  // Stage 1: products of u x v.
  logic signed [39:0] cp_r [3];
  logic signed [39:0] cn_r [3];
  logic signed [23:0] v1_r [3];
  logic signed [23:0] p21_r [3];
  logic signed [15:0] u1_r [3];
  logic signed [15:0] w1_r;

  // Stage 2: t = round(2 * (u x v)).
  logic signed [28:0] t2_r [3];
  logic signed [28:0] t2_nxt [3];
  logic signed [23:0] v2_r [3];
  logic signed [23:0] p22_r [3];
  logic signed [15:0] u2_r [3];
  logic signed [15:0] w2_r;

  // Stage 3: products of w * t and u x t.
  logic signed [44:0] wt3_r [3];
  logic signed [44:0] tp3_r [3];
  logic signed [44:0] tn3_r [3];
  logic signed [23:0] v3_r [3];
  logic signed [23:0] p23_r [3];

  // Stage 4: output register.
  logic signed [23:0] pos4_r [3];
  logic signed [23:0] pos4_nxt [3];

  assign v_in[0]  = first_pos.x;
  assign v_in[1]  = first_pos.y;
  assign v_in[2]  = first_pos.z;
  assign p2_in[0] = second_pos.x;
  assign p2_in[1] = second_pos.y;
  assign p2_in[2] = second_pos.z;
  assign u_in[0]  = second_rot.x;
  assign u_in[1]  = second_rot.y;
  assign u_in[2]  = second_rot.z;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    logic signed [41:0] c_ext;
    logic signed [41:0] t_ext;
    logic signed [46:0] s_sum;
    logic signed [46:0] s_rnd;
    logic signed [32:0] rot;
    logic signed [34:0] pos_sum;

    always_ff @(posedge clk) begin
      if (ctrl.en[0]) begin
        cp_r[i]  <= u_in[J] * v_in[K];
        cn_r[i]  <= u_in[K] * v_in[J];
        v1_r[i]  <= v_in[i];
        p21_r[i] <= p2_in[i];
        u1_r[i]  <= u_in[i];
      end
    end

    // Doubling then dropping 14 bits is the same as dropping 13.
    always_comb begin
      c_ext     = 42'(cp_r[i]) - 42'(cn_r[i]);
      t_ext     = (c_ext + 42'sd4096) >>> (pc_pkg::QUAT_FRAC - 1);
      t2_nxt[i] = t_ext[28:0];
    end

    always_ff @(posedge clk) begin
      if (ctrl.en[1]) begin
        t2_r[i]  <= t2_nxt[i];
        v2_r[i]  <= v1_r[i];
        p22_r[i] <= p21_r[i];
        u2_r[i]  <= u1_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.en[2]) begin
        wt3_r[i] <= w2_r * t2_r[i];
        tp3_r[i] <= u2_r[J] * t2_r[K];
        tn3_r[i] <= u2_r[K] * t2_r[J];
        v3_r[i]  <= v2_r[i];
        p23_r[i] <= p22_r[i];
      end
    end

    always_comb begin
      s_sum       = 47'(wt3_r[i]) + 47'(tp3_r[i]) - 47'(tn3_r[i]);
      s_rnd       = (s_sum + 47'sd8192) >>> pc_pkg::QUAT_FRAC;
      rot         = s_rnd[32:0];
      pos_sum     = 35'(v3_r[i]) + 35'(rot) + 35'(p23_r[i]);
      pos4_nxt[i] = pc_pkg::sat_pos(pos_sum);
    end

    always_ff @(posedge clk) begin
      if (ctrl.en[3]) begin
        pos4_r[i] <= pos4_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      w1_r <= second_rot.w;
    end
    if (ctrl.en[1]) begin
      w2_r <= w1_r;
    end
  end

  assign pos_out.x = pos4_r[0];
  assign pos_out.y = pos4_r[1];
  assign pos_out.z = pos4_r[2];

endmodule

@@ rtl/core/pc_checker.sv @@
// Port-level checks for the pose composition block, bound to the top level.
// Sees only the top level's ports; depends on pc_pkg for widths.
module pc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [pc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [pc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled output word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed or dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A ready receiver means every stage can move, so the input is ready too.
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while receiver ready");

  // With the receiver ready throughout, an accepted word must reach the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("accepted word did not reach the output in time");

  logic unused_in;
  assign unused_in = ^in_tdata;

endmodule

bind pose_composition pc_checker u_pc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/tb_pose_composition.sv @@
// Self-checking bench for pose_composition: drives pose pairs on the input
// stream, predicts each composed pose and checks every output word against it.
// Depends on pc_pkg and the pose_composition RTL.
module tb_pose_composition;
  timeunit 1ns;
  timeprecision 1ps;

  // Bus layout of one input word and one output word, lowest field last.
  typedef struct packed {
    pc_pkg::quat_t    second_rot;
    pc_pkg::pos_vec_t second_pos;
    pc_pkg::quat_t    first_rot;
    pc_pkg::pos_vec_t first_pos;
  } pose_pair_t;

  typedef struct packed {
    pc_pkg::quat_t    quat;
    pc_pkg::pos_vec_t pos;
  } composed_pose_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [pc_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [pc_pkg::OUT_DATA_W-1:0] out_tdata;

  pose_pair_t     pending_pairs[$];
  composed_pose_t expected_poses[$];
  int             mismatch_count = 0;
  logic           tail_calm = 1'b0;
  int             in_gap_left = 0;
  int             in_gap_odds = 0;
  int             out_stall_left = 0;
  int             out_stall_odds = 0;
  string          result_field_name[7] = '{"pos_x", "pos_y", "pos_z",
                                           "quat_x", "quat_y", "quat_z", "quat_w"};

  pose_composition u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Adding half an LSB and shifting arithmetically rounds ties upwards.
  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic composed_pose_t compose_poses(input pose_pair_t pp);
    longint p1[3];
    longint p2[3];
    longint a[4];
    longint b[4];
    longint t[3];
    longint q[4];
    longint pos_r[3];
    longint rot;
    int j;
    int k;
    composed_pose_t res;
    p1 = '{pp.first_pos.x, pp.first_pos.y, pp.first_pos.z};
    p2 = '{pp.second_pos.x, pp.second_pos.y, pp.second_pos.z};
    a = '{pp.second_rot.x, pp.second_rot.y, pp.second_rot.z, pp.second_rot.w};
    b = '{pp.first_rot.x, pp.first_rot.y, pp.first_rot.z, pp.first_rot.w};
    // Hamilton product second * first, summed exactly before one rounding.
    q[0] = a[3] * b[0] + a[0] * b[3] + a[1] * b[2] - a[2] * b[1];
    q[1] = a[3] * b[1] - a[0] * b[2] + a[1] * b[3] + a[2] * b[0];
    q[2] = a[3] * b[2] + a[0] * b[1] - a[1] * b[0] + a[2] * b[3];
    q[3] = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
    // t is twice the cross product of the vector part with the position.
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      t[i] = round_half_up(2 * (a[j] * p1[k] - a[k] * p1[j]), pc_pkg::QUAT_FRAC);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      rot = round_half_up(a[3] * t[i] + a[j] * t[k] - a[k] * t[j], pc_pkg::QUAT_FRAC);
      pos_r[i] = saturate(p1[i] + rot + p2[i], pc_pkg::POS_W);
    end
    res.pos.x  = pc_pkg::pos_t'(pos_r[0]);
    res.pos.y  = pc_pkg::pos_t'(pos_r[1]);
    res.pos.z  = pc_pkg::pos_t'(pos_r[2]);
    res.quat.x = pc_pkg::qcomp_t'(saturate(round_half_up(q[0], pc_pkg::QUAT_FRAC),
                                           pc_pkg::QUAT_W));
    res.quat.y = pc_pkg::qcomp_t'(saturate(round_half_up(q[1], pc_pkg::QUAT_FRAC),
                                           pc_pkg::QUAT_W));
    res.quat.z = pc_pkg::qcomp_t'(saturate(round_half_up(q[2], pc_pkg::QUAT_FRAC),
                                           pc_pkg::QUAT_W));
    res.quat.w = pc_pkg::qcomp_t'(saturate(round_half_up(q[3], pc_pkg::QUAT_FRAC),
                                           pc_pkg::QUAT_W));
    return res;
  endfunction

  function automatic pc_pkg::quat_t mk_quat(input int x, input int y,
                                            input int z, input int w);
    pc_pkg::quat_t r;
    r.x = pc_pkg::qcomp_t'(x);
    r.y = pc_pkg::qcomp_t'(y);
    r.z = pc_pkg::qcomp_t'(z);
    r.w = pc_pkg::qcomp_t'(w);
    return r;
  endfunction

  function automatic pc_pkg::pos_vec_t mk_pos(input int x, input int y, input int z);
    pc_pkg::pos_vec_t r;
    r.x = pc_pkg::pos_t'(x);
    r.y = pc_pkg::pos_t'(y);
    r.z = pc_pkg::pos_t'(z);
    return r;
  endfunction

  function automatic pc_pkg::pos_t random_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       return 24'sh7FFFFF;
        1:       return 24'sh800000;
        2:       return 24'sh000000;
        default: return 24'shFFFFFF;
      endcase
    end else if (pick < 4) begin
      return pc_pkg::pos_t'($urandom);
    end
    return pc_pkg::pos_t'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic pc_pkg::qcomp_t random_comp(input bit wild);
    if (wild) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'sh4000;
        default: return pc_pkg::qcomp_t'($urandom);
      endcase
    end
    // Components within about one over root two keep the norm at most about root two.
    return pc_pkg::qcomp_t'(int'($urandom_range(0, 23170)) - 11585);
  endfunction

  function automatic pc_pkg::quat_t random_quat();
    pc_pkg::quat_t r;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      r = {$urandom, $urandom};
    end else begin
      r.x = random_comp(pick == 2);
      r.y = random_comp(pick == 2);
      r.z = random_comp(pick == 2);
      r.w = random_comp(pick == 2);
    end
    return r;
  endfunction

  task automatic queue_pair(input pc_pkg::pos_vec_t p1, input pc_pkg::quat_t q1,
                            input pc_pkg::pos_vec_t p2, input pc_pkg::quat_t q2);
    pose_pair_t pp;
    pp.first_pos  = p1;
    pp.first_rot  = q1;
    pp.second_pos = p2;
    pp.second_rot = q2;
    pending_pairs.push_back(pp);
  endtask

  // Input side: presents the next pending word, with bursts of idle cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_poses.push_back(compose_poses(pose_pair_t'(in_tdata)));
      end
      tail_calm <= (pending_pairs.size() < 200);
      if (!in_tvalid || in_tready) begin
        if ($urandom_range(0, 63) == 0) begin
          case ($urandom_range(0, 2))
            0:       in_gap_odds = 0;
            1:       in_gap_odds = 4;
            default: in_gap_odds = 16;
          endcase
        end
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_tvalid <= 1'b0;
        end else if (!tail_calm && in_gap_odds != 0 &&
                     $urandom_range(1, in_gap_odds) == 1) begin
          in_gap_left = $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          in_tdata  <= pending_pairs.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each accepted word and stalls in random bursts.
  always @(posedge clk) begin
    composed_pose_t got;
    composed_pose_t want;
    int want_f[7];
    int got_f[7];
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_poses.size() == 0) begin
          $display("%0t: unexpected output word %h", $realtime, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_poses.pop_front();
          want_f = '{want.pos.x, want.pos.y, want.pos.z,
                     want.quat.x, want.quat.y, want.quat.z, want.quat.w};
          got_f = '{got.pos.x, got.pos.y, got.pos.z,
                    got.quat.x, got.quat.y, got.quat.z, got.quat.w};
          for (int i = 0; i < 7; i++) begin
            if (want_f[i] != got_f[i]) begin
              $display("%0t: %s mismatch, expected %0d, actual %0d",
                       $realtime, result_field_name[i], want_f[i], got_f[i]);
              mismatch_count++;
            end
          end
        end
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0:       out_stall_odds = 0;
          1:       out_stall_odds = 4;
          default: out_stall_odds = 16;
        endcase
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_tready <= 1'b0;
      end else if (!tail_calm && out_stall_odds != 0 &&
                   $urandom_range(1, out_stall_odds) == 1) begin
        out_stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    pc_pkg::quat_t ident;
    ident = mk_quat(0, 0, 0, 16384);

    queue_pair(mk_pos(0, 0, 0), ident, mk_pos(0, 0, 0), ident);
    queue_pair(mk_pos(4096, -8192, 12288), ident, mk_pos(1, 2, 3), ident);
    // Translations that overflow in both directions.
    queue_pair(mk_pos(8388607, 8388607, 8388607), ident,
               mk_pos(8388607, 8388607, 8388607), ident);
    queue_pair(mk_pos(-8388608, -8388608, -8388608), ident,
               mk_pos(-8388608, -8388608, -8388608), ident);
    // Quarter turn about z, half turn about x.
    queue_pair(mk_pos(4096, 0, 0), ident, mk_pos(0, 0, 0), mk_quat(0, 0, 11585, 11585));
    queue_pair(mk_pos(8388607, 8388607, -8388608), ident,
               mk_pos(0, 0, 0), mk_quat(16384, 0, 0, 0));
    queue_pair(mk_pos(40960, -4096, 81920), mk_quat(11585, 0, 0, 11585),
               mk_pos(-100, 200, -300), mk_quat(0, 11585, 0, 11585));
    // Non-unit quaternions at the ends of the range saturate the products.
    queue_pair(mk_pos(1000, 2000, 3000), mk_quat(32767, 32767, 32767, 32767),
               mk_pos(0, 0, 0), mk_quat(32767, 32767, 32767, 32767));
    queue_pair(mk_pos(-1000, 2000, -3000), mk_quat(-32768, -32768, -32768, -32768),
               mk_pos(5, 6, 7), mk_quat(-32768, -32768, -32768, -32768));
    queue_pair(mk_pos(0, 0, 0), mk_quat(32767, -32768, 32767, -32768),
               mk_pos(0, 0, 0), mk_quat(-32768, 32767, -32768, 32767));
    queue_pair(mk_pos(8388607, -8388608, 8388607), ident,
               mk_pos(0, 0, 0), mk_quat(32767, 32767, 32767, 32767));
    queue_pair(mk_pos(-8388608, 8388607, -8388608), ident,
               mk_pos(8388607, -8388608, 0), mk_quat(-32768, 32767, -32768, 32767));
    // Exact halves of an output LSB, positive and negative.
    queue_pair(mk_pos(0, 0, 0), mk_quat(8192, 0, 0, 0), mk_pos(0, 0, 0), mk_quat(0, 0, 0, 1));
    queue_pair(mk_pos(0, 0, 0), mk_quat(-8192, 0, 0, 0), mk_pos(0, 0, 0), mk_quat(0, 0, 0, 1));
    queue_pair(mk_pos(0, 4096, 2048), ident, mk_pos(0, 0, 0), mk_quat(1, 0, 0, 16384));
    queue_pair(mk_pos(123456, -654321, 777), mk_quat(0, 0, 0, 0),
               mk_pos(-1, 1, -1), mk_quat(0, 0, 0, 0));
    queue_pair(mk_pos(-1, -1, -1), mk_quat(-1, -1, -1, -1),
               mk_pos(-1, -1, -1), mk_quat(-1, -1, -1, -1));
    queue_pair(mk_pos(24'h555555, 24'haaaaaa, 24'h555555),
               mk_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa),
               mk_pos(24'haaaaaa, 24'h555555, 24'haaaaaa),
               mk_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));

    for (int n = 0; n < 1800; n++) begin
      queue_pair(mk_pos(random_coord(), random_coord(), random_coord()), random_quat(),
                 mk_pos(random_coord(), random_coord(), random_coord()), random_quat());
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    // A word still awaited here was lost in the pipeline.
    if (mismatch_count == 0 && expected_poses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
